// File: hw/rtl/tsedg_pkg.sv
// ----------------------------------------------------------------------------
// tsedg_pkg
// Shared widths, register indexes and the register file type of the tensor
// spline element dof generator.
// ----------------------------------------------------------------------------
package tsedg_pkg;

   // default configuration of the generator
   localparam int MAX_DIMS_DEF   = 3;
   localparam int BASIS_BITS_DEF = 10;
   localparam int MAX_DEGREE_DEF = 3;

   // fixed field widths
   localparam int NDIM       = 3;
   localparam int DIMS_W     = 2;
   localparam int CNT_W      = 11;
   localparam int DEG_W      = 2;
   localparam int IDX_W      = 31;
   localparam int SPAN_W     = 11;
   localparam int DOF_W      = 30;
   localparam int RES_W      = DOF_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DIMS          = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASIS_COUNT_U = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASIS_COUNT_V = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASIS_COUNT_W = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEGREE_U      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEGREE_V      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEGREE_W      = 3'd6;

   // raw register contents as written
   typedef struct packed {
      logic [DIMS_W-1:0] dims;
      logic [CNT_W-1:0]  basis_count_u;
      logic [CNT_W-1:0]  basis_count_v;
      logic [CNT_W-1:0]  basis_count_w;
      logic [DEG_W-1:0]  degree_u;
      logic [DEG_W-1:0]  degree_v;
      logic [DEG_W-1:0]  degree_w;
   } csr_regs_type;

endpackage

// File: hw/rtl/tensor_spline_element_dof_gen_unit.sv
// ----------------------------------------------------------------------------
// tensor_spline_element_dof_gen_unit
// Enumerates the global basis indices touched by one element of a 1 to 3
// dimensional tensor-product spline grid.
// ----------------------------------------------------------------------------
// A flat element beat first runs the mixed-radix split, a restoring divider
// that settles 8 quotient bits a cycle over each dimension in use, then the
// range, multiply and job stages; a span beat goes straight to the range,
// multiply and job stages. The back end then emits one dof index per cycle
// while the result queue has room, the product of (hi-lo+1) over the
// dimensions, or one beat for an out-of-range element. Front and back are
// split by a 4-deep job queue and results leave through a 2-deep result
// queue, so the sustained cost per element is set by the slower of the two.
// No clearing pass after reset. Configuration registers are written through
// the csr channel, which is always ready.
// ----------------------------------------------------------------------------
module tensor_spline_element_dof_gen_unit #(
   parameter int MAX_DIMS   = tsedg_pkg::MAX_DIMS_DEF,
   parameter int BASIS_BITS = tsedg_pkg::BASIS_BITS_DEF,
   parameter int MAX_DEGREE = tsedg_pkg::MAX_DEGREE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // element beats
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_kind,
   input  logic [tsedg_pkg::IDX_W-1:0]     req_element_index,
   input  logic [tsedg_pkg::SPAN_W-1:0]    req_span_u,
   input  logic [tsedg_pkg::SPAN_W-1:0]    req_span_v,
   input  logic [tsedg_pkg::SPAN_W-1:0]    req_span_w,
   // result beats
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [tsedg_pkg::DOF_W-1:0]     rsp_dof_index,
   output logic                            rsp_is_last,
   output logic                            rsp_range_error,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tsedg_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [tsedg_pkg::CSR_DATA_W-1:0] csr_data
);

   import tsedg_pkg::*;

   localparam int JOB_W     = 1 + 7 * BASIS_BITS + 1 + 2 * DOF_W;
   localparam int JOB_DEPTH = 4;
   localparam int RES_DEPTH = 2;

   csr_regs_type     csr_ff, csr_in;
   logic             csr_we;
   logic             job_push;
   logic [JOB_W-1:0] job_wdata;
   logic             job_full;
   logic             job_pop;
   logic [JOB_W-1:0] job_rdata;
   logic             job_empty;
   logic             res_push;
   logic [RES_W-1:0] res_wdata;
   logic             res_full;
   logic [RES_W-1:0] res_rdata;

   // configuration register file
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIMS:          csr_in.dims          = csr_data[DIMS_W-1:0];
            CSR_BASIS_COUNT_U: csr_in.basis_count_u = csr_data[CNT_W-1:0];
            CSR_BASIS_COUNT_V: csr_in.basis_count_v = csr_data[CNT_W-1:0];
            CSR_BASIS_COUNT_W: csr_in.basis_count_w = csr_data[CNT_W-1:0];
            CSR_DEGREE_U:      csr_in.degree_u      = csr_data[DEG_W-1:0];
            CSR_DEGREE_V:      csr_in.degree_v      = csr_data[DEG_W-1:0];
            CSR_DEGREE_W:      csr_in.degree_w      = csr_data[DEG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.dims          <= DIMS_W'(3);
         csr_ff.basis_count_u <= CNT_W'(1);
         csr_ff.basis_count_v <= CNT_W'(1);
         csr_ff.basis_count_w <= CNT_W'(1);
         csr_ff.degree_u      <= '0;
         csr_ff.degree_v      <= '0;
         csr_ff.degree_w      <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // element intake and job building
   tsedg_front #(
      .MAX_DIMS   (MAX_DIMS),
      .BASIS_BITS (BASIS_BITS),
      .MAX_DEGREE (MAX_DEGREE),
      .JOB_W      (JOB_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_regs          (csr_ff),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_element_index (req_element_index),
      .req_span_u        (req_span_u),
      .req_span_v        (req_span_v),
      .req_span_w        (req_span_w),
      .job_push          (job_push),
      .job_data          (job_wdata),
      .job_full          (job_full)
   );

   // jobs between front and back
   tsedg_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wdata),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rdata),
      .empty     (job_empty)
   );

   // box walk
   tsedg_back #(
      .BASIS_BITS (BASIS_BITS),
      .JOB_W      (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (job_rdata),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .res_push  (res_push),
      .res_data  (res_wdata),
      .res_full  (res_full)
   );

   // result beats waiting to be taken
   tsedg_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RES_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wdata),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_rdata),
      .empty     (rsp_empty)
   );

   assign {rsp_dof_index, rsp_is_last, rsp_range_error} = res_rdata;

endmodule

// File: hw/rtl/tsedg_fifo.sv
// ----------------------------------------------------------------------------
// tsedg_fifo
// Small register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tsedg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             wr_en;
   logic             rd_en;

   assign full     = (level_ff == LVL_W'(DEPTH));
   assign empty    = (level_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         level_in = level_ff + LVL_W'(1);
      end else if (rd_en && !wr_en) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/tsedg_front.sv
// ----------------------------------------------------------------------------
// tsedg_front
// Accepts element beats, splits flat element numbers into spans with an
// iterative divider, checks ranges and builds one job per element.
// ----------------------------------------------------------------------------
module tsedg_front #(
   parameter int MAX_DIMS   = tsedg_pkg::MAX_DIMS_DEF,
   parameter int BASIS_BITS = tsedg_pkg::BASIS_BITS_DEF,
   parameter int MAX_DEGREE = tsedg_pkg::MAX_DEGREE_DEF,
   parameter int JOB_W      = 1 + 7 * BASIS_BITS + 1 + 2 * tsedg_pkg::DOF_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsedg_pkg::csr_regs_type        csr_regs,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_kind,
   input  logic [tsedg_pkg::IDX_W-1:0]    req_element_index,
   input  logic [tsedg_pkg::SPAN_W-1:0]   req_span_u,
   input  logic [tsedg_pkg::SPAN_W-1:0]   req_span_v,
   input  logic [tsedg_pkg::SPAN_W-1:0]   req_span_w,
   output logic                           job_push,
   output logic [JOB_W-1:0]               job_data,
   input  logic                           job_full
);

   import tsedg_pkg::*;

   localparam int BB       = BASIS_BITS;
   localparam int NB       = BASIS_BITS + 1;
   localparam int RB       = $clog2(2 ** BASIS_BITS + MAX_DEGREE + 1);
   localparam int CMP_W    = (NB > CNT_W) ? NB : CNT_W;
   localparam int SCMP_W   = (RB > SPAN_W) ? RB : SPAN_W;
   localparam int DIV_STEP = 8;
   localparam int QW       = ((IDX_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int STEP_CNT = QW / DIV_STEP;
   localparam int SC_W     = (STEP_CNT > 1) ? $clog2(STEP_CNT) : 1;
   localparam logic [CMP_W-1:0] N_CAP     = CMP_W'(2 ** BASIS_BITS);
   localparam logic [SC_W-1:0]  STEP_LAST = SC_W'(STEP_CNT - 1);

   typedef enum logic [4:0] {
      FS_IDLE  = 5'b00001,
      FS_DIV   = 5'b00010,
      FS_RANGE = 5'b00100,
      FS_MUL   = 5'b01000,
      FS_PUSH  = 5'b10000
   } front_state_type;

   // clamped configuration
   logic [CNT_W-1:0]  cnt_c [NDIM];
   logic [DEG_W-1:0]  deg_c [NDIM];
   logic [DIMS_W-1:0] nd_c;
   logic [NB-1:0]     n_c [NDIM];
   logic [DEG_W-1:0]  p_c [NDIM];
   logic [CMP_W-1:0]  cnt_ext;
   logic [DOF_W-1:0]  stride_c;

   logic [DIMS_W-1:0] nd_ff;
   logic [NB-1:0]     n_ff [NDIM];
   logic [DEG_W-1:0]  p_ff [NDIM];
   logic [RB-1:0]     r_ff [NDIM];
   logic [DOF_W-1:0]  stride_ff;

   // input holding stage
   logic              hold_valid_ff, hold_valid_in;
   logic              hold_kind_ff;
   logic [IDX_W-1:0]  hold_elem_ff;
   logic [SPAN_W-1:0] hold_span_ff [NDIM];
   logic [SPAN_W-1:0] req_span [NDIM];
   logic              accept;
   logic              take;

   // element state
   front_state_type   state_ff, state_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [RB-1:0]     rem_ff, rem_in;
   logic [SC_W-1:0]   step_ff, step_in;
   logic [DIMS_W-1:0] dim_ff, dim_in;
   logic              err_ff, err_in;
   logic [RB-1:0]     s_ff [NDIM];
   logic [RB-1:0]     s_in [NDIM];
   logic [BB-1:0]     lo_ff [NDIM];
   logic [BB-1:0]     lo_in [NDIM];
   logic [BB-1:0]     hi_ff [NDIM];
   logic [BB-1:0]     hi_in [NDIM];
   logic [DOF_W-1:0]  m1_ff, m1_in;
   logic [DOF_W-1:0]  m2_ff, m2_in;
   logic [DOF_W-1:0]  start;

   // divider datapath
   logic [QW-1:0]     q_v;
   logic [RB-1:0]     rem_v;
   logic [RB:0]       trial;
   logic [RB-1:0]     r_sel;

   // range check of given spans
   logic              span_bad;
   logic [NB-1:0]     nm1;

   assign cnt_c[0] = csr_regs.basis_count_u;
   assign cnt_c[1] = csr_regs.basis_count_v;
   assign cnt_c[2] = csr_regs.basis_count_w;
   assign deg_c[0] = csr_regs.degree_u;
   assign deg_c[1] = csr_regs.degree_v;
   assign deg_c[2] = csr_regs.degree_w;
   assign req_span[0] = req_span_u;
   assign req_span[1] = req_span_v;
   assign req_span[2] = req_span_w;

   // clamp dimension count, basis counts and degrees; unused dims are n=1, p=0
   always_comb begin
      if (csr_regs.dims == '0) begin
         nd_c = DIMS_W'(1);
      end else if (csr_regs.dims > DIMS_W'(MAX_DIMS)) begin
         nd_c = DIMS_W'(MAX_DIMS);
      end else begin
         nd_c = csr_regs.dims;
      end
      cnt_ext = '0;
      for (int d = 0; d < NDIM; d++) begin
         cnt_ext = CMP_W'(cnt_c[d]);
         if (DIMS_W'(d) >= nd_c || cnt_ext == '0) begin
            n_c[d] = NB'(1);
         end else if (cnt_ext > N_CAP) begin
            n_c[d] = NB'(N_CAP);
         end else begin
            n_c[d] = NB'(cnt_ext);
         end
         if (DIMS_W'(d) >= nd_c) begin
            p_c[d] = '0;
         end else if (deg_c[d] > DEG_W'(MAX_DEGREE)) begin
            p_c[d] = DEG_W'(MAX_DEGREE);
         end else begin
            p_c[d] = deg_c[d];
         end
      end
      stride_c = DOF_W'(n_c[0]) * DOF_W'(n_c[1]);
   end

   always_ff @(posedge clock) begin
      nd_ff     <= nd_c;
      stride_ff <= stride_c;
      for (int d = 0; d < NDIM; d++) begin
         n_ff[d] <= n_c[d];
         p_ff[d] <= p_c[d];
         r_ff[d] <= RB'(n_c[d]) + RB'(p_c[d]);
      end
   end

   // several quotient bits per cycle, restoring
   assign r_sel = r_ff[dim_ff];
   always_comb begin
      q_v   = q_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int k = 0; k < DIV_STEP; k++) begin
         trial = {rem_v, q_v[QW-1]};
         q_v   = {q_v[QW-2:0], 1'b0};
         if (trial >= {1'b0, r_sel}) begin
            trial  = trial - {1'b0, r_sel};
            q_v[0] = 1'b1;
         end
         rem_v = trial[RB-1:0];
      end
   end

   // any span in use at or past its interval count
   always_comb begin
      span_bad = 1'b0;
      for (int d = 0; d < NDIM; d++) begin
         if (DIMS_W'(d) < nd_ff && SCMP_W'(hold_span_ff[d]) >= SCMP_W'(r_ff[d])) begin
            span_bad = 1'b1;
         end
      end
   end

   assign take     = hold_valid_ff &&
                     (state_ff == FS_IDLE || (state_ff == FS_PUSH && !job_full));
   assign req_full = hold_valid_ff && !take;
   assign accept   = req_push && !req_full;
   assign job_push = (state_ff == FS_PUSH) && !job_full;
   assign start    = DOF_W'(lo_ff[0]) + m1_ff + m2_ff;
   assign job_data = {err_ff, lo_ff[0], hi_ff[0], lo_ff[1], hi_ff[1], lo_ff[2], hi_ff[2],
                      start, n_ff[0], stride_ff};

   // element sequencer
   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      dim_in   = dim_ff;
      err_in   = err_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      nm1      = '0;
      s_in     = s_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;

      case (state_ff)
         FS_IDLE: begin
         end
         FS_DIV: begin
            q_in    = q_v;
            rem_in  = rem_v;
            step_in = step_ff + SC_W'(1);
            if (step_ff == STEP_LAST) begin
               s_in[dim_ff] = rem_v;
               rem_in       = '0;
               step_in      = '0;
               if ((dim_ff + DIMS_W'(1)) < nd_ff) begin
                  dim_in = dim_ff + DIMS_W'(1);
               end else begin
                  err_in   = (q_v != '0);
                  state_in = (q_v != '0) ? FS_PUSH : FS_RANGE;
               end
            end
         end
         FS_RANGE: begin
            for (int d = 0; d < NDIM; d++) begin
               nm1 = n_ff[d] - NB'(1);
               lo_in[d] = (s_ff[d] >= RB'(p_ff[d])) ? BB'(s_ff[d] - RB'(p_ff[d])) : '0;
               hi_in[d] = (RB'(nm1) > s_ff[d]) ? BB'(s_ff[d]) : BB'(nm1);
            end
            state_in = FS_MUL;
         end
         FS_MUL: begin
            m1_in    = DOF_W'(lo_ff[1]) * DOF_W'(n_ff[0]);
            m2_in    = DOF_W'(lo_ff[2]) * stride_ff;
            state_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (!job_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase

      // start the next element as soon as the current job leaves
      if (take) begin
         q_in    = QW'(hold_elem_ff);
         rem_in  = '0;
         step_in = '0;
         dim_in  = '0;
         if (!hold_kind_ff) begin
            err_in   = 1'b0;
            state_in = FS_DIV;
            for (int d = 0; d < NDIM; d++) begin
               s_in[d] = '0;
            end
         end else begin
            err_in   = span_bad;
            state_in = span_bad ? FS_PUSH : FS_RANGE;
            for (int d = 0; d < NDIM; d++) begin
               s_in[d] = (DIMS_W'(d) < nd_ff) ? RB'(hold_span_ff[d]) : '0;
            end
         end
      end

      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (take) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FS_IDLE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_kind_ff <= req_kind;
         hold_elem_ff <= req_element_index;
         for (int d = 0; d < NDIM; d++) begin
            hold_span_ff[d] <= req_span[d];
         end
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      dim_ff  <= dim_in;
      err_ff  <= err_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      s_ff    <= s_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

endmodule

// File: hw/rtl/tsedg_back.sv
// ----------------------------------------------------------------------------
// tsedg_back
// Walks one job's active basis box, u outermost and w innermost, with running
// offsets, giving one global dof index per cycle unless a queue stalls it.
// ----------------------------------------------------------------------------
module tsedg_back #(
   parameter int BASIS_BITS = tsedg_pkg::BASIS_BITS_DEF,
   parameter int JOB_W      = 1 + 7 * BASIS_BITS + 1 + 2 * tsedg_pkg::DOF_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [JOB_W-1:0]            job_data,
   input  logic                        job_empty,
   output logic                        job_pop,
   output logic                        res_push,
   output logic [tsedg_pkg::RES_W-1:0] res_data,
   input  logic                        res_full
);

   import tsedg_pkg::*;

   localparam int BB = BASIS_BITS;
   localparam int NB = BASIS_BITS + 1;

   // job fields
   logic             j_err;
   logic [BB-1:0]    lo0, hi0, lo1, hi1, lo2, hi2;
   logic [DOF_W-1:0] j_start;
   logic [NB-1:0]    j_n0;
   logic [DOF_W-1:0] j_stride;

   // walk state
   logic             loaded_ff, loaded_in;
   logic [BB-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [DOF_W-1:0] g_ff, g_in, ga_ff, ga_in, gb_ff, gb_in;
   logic [BB-1:0]    a_cur, b_cur, c_cur;
   logic [DOF_W-1:0] g_cur, ga_cur, gb_cur;
   logic             fire;
   logic             box_last;
   logic             job_done;

   assign {j_err, lo0, hi0, lo1, hi1, lo2, hi2, j_start, j_n0, j_stride} = job_data;

   // first beat of a job comes straight from the queue head
   assign a_cur  = loaded_ff ? a_ff : lo0;
   assign b_cur  = loaded_ff ? b_ff : lo1;
   assign c_cur  = loaded_ff ? c_ff : lo2;
   assign g_cur  = loaded_ff ? g_ff : j_start;
   assign ga_cur = loaded_ff ? ga_ff : j_start;
   assign gb_cur = loaded_ff ? gb_ff : j_start;

   assign fire     = !job_empty && !res_full;
   assign box_last = (a_cur == hi0) && (b_cur == hi1) && (c_cur == hi2);
   assign job_done = j_err || box_last;
   assign job_pop  = fire && job_done;
   assign res_push = fire;
   assign res_data = j_err ? {{DOF_W{1'b0}}, 1'b1, 1'b1} : {g_cur, box_last, 1'b0};

   // next position inside the box
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      g_in      = g_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      loaded_in = loaded_ff;
      if (fire) begin
         loaded_in = !job_done;
         a_in      = a_cur;
         b_in      = b_cur;
         ga_in     = ga_cur;
         gb_in     = gb_cur;
         if (c_cur != hi2) begin
            c_in = c_cur + BB'(1);
            g_in = g_cur + j_stride;
         end else if (b_cur != hi1) begin
            b_in  = b_cur + BB'(1);
            c_in  = lo2;
            gb_in = gb_cur + DOF_W'(j_n0);
            g_in  = gb_cur + DOF_W'(j_n0);
         end else begin
            a_in  = a_cur + BB'(1);
            b_in  = lo1;
            c_in  = lo2;
            ga_in = ga_cur + DOF_W'(1);
            gb_in = ga_cur + DOF_W'(1);
            g_in  = ga_cur + DOF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      c_ff  <= c_in;
      g_ff  <= g_in;
      ga_ff <= ga_in;
      gb_ff <= gb_in;
   end

endmodule
